// ----- design/smi_pkg.sv -----
package smi_pkg;

  localparam int DATA_W      = 32;
  localparam int MAX_ORDER   = 4;
  localparam int ORDER_W     = 3;
  localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int ADDR_W      = 4;
  localparam int CNT_W       = 5;
  localparam int PROD_W      = 128;
  localparam int ACC_W       = 132;
  localparam int QUO_W       = 34;
  localparam int PERM_IDX_W  = 5;
  localparam int LAST_PERM   = 23;
  localparam int DIV_LAST    = 32;
  localparam int STEP_W      = 6;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [CFG_ADDR_W-1:0] CFG_ORDER_ADDR = 3'd0;
  localparam logic [ORDER_W-1:0]    ORDER_RESET    = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACC_CLR,
    OP_PROD_INIT,
    OP_ELEM,
    OP_MUL,
    OP_ACC_ADD,
    OP_DET_TAKE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ROUND,
    OP_OUT_RES,
    OP_OUT_SING
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] limb;
    logic       odd;
    logic       first;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_zero;
    logic out_free;
  } dp_status_t;

  function automatic logic [ORDER_W-1:0] order_clamp(input logic [ORDER_W-1:0] ord);
    logic [ORDER_W-1:0] n;
    n = ord;
    if (ord == 3'd0) n = 3'd1;
    if (ord > ORDER_W'(MAX_ORDER)) n = ORDER_W'(MAX_ORDER);
    return n;
  endfunction

  // {odd parity, p3, p2, p1, p0}: permutations of four in lexicographic order
  function automatic logic [8:0] perm_entry(input logic [PERM_IDX_W-1:0] idx);
    logic [8:0] e;
    case (idx)
      5'd0:    e = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
      5'd1:    e = {1'b1, 2'd2, 2'd3, 2'd1, 2'd0};
      5'd2:    e = {1'b1, 2'd3, 2'd1, 2'd2, 2'd0};
      5'd3:    e = {1'b0, 2'd1, 2'd3, 2'd2, 2'd0};
      5'd4:    e = {1'b0, 2'd2, 2'd1, 2'd3, 2'd0};
      5'd5:    e = {1'b1, 2'd1, 2'd2, 2'd3, 2'd0};
      5'd6:    e = {1'b1, 2'd3, 2'd2, 2'd0, 2'd1};
      5'd7:    e = {1'b0, 2'd2, 2'd3, 2'd0, 2'd1};
      5'd8:    e = {1'b0, 2'd3, 2'd0, 2'd2, 2'd1};
      5'd9:    e = {1'b1, 2'd0, 2'd3, 2'd2, 2'd1};
      5'd10:   e = {1'b1, 2'd2, 2'd0, 2'd3, 2'd1};
      5'd11:   e = {1'b0, 2'd0, 2'd2, 2'd3, 2'd1};
      5'd12:   e = {1'b0, 2'd3, 2'd1, 2'd0, 2'd2};
      5'd13:   e = {1'b1, 2'd1, 2'd3, 2'd0, 2'd2};
      5'd14:   e = {1'b1, 2'd3, 2'd0, 2'd1, 2'd2};
      5'd15:   e = {1'b0, 2'd0, 2'd3, 2'd1, 2'd2};
      5'd16:   e = {1'b0, 2'd1, 2'd0, 2'd3, 2'd2};
      5'd17:   e = {1'b1, 2'd0, 2'd1, 2'd3, 2'd2};
      5'd18:   e = {1'b1, 2'd2, 2'd1, 2'd0, 2'd3};
      5'd19:   e = {1'b0, 2'd1, 2'd2, 2'd0, 2'd3};
      5'd20:   e = {1'b0, 2'd2, 2'd0, 2'd1, 2'd3};
      5'd21:   e = {1'b1, 2'd0, 2'd2, 2'd1, 2'd3};
      5'd22:   e = {1'b1, 2'd1, 2'd0, 2'd2, 2'd3};
      5'd23:   e = {1'b0, 2'd0, 2'd1, 2'd2, 2'd3};
      default: e = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
    endcase
    return e;
  endfunction

endpackage

// ----- design/smi_ram.sv -----
module smi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/smi_ctrl.sv -----
module smi_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [smi_pkg::ORDER_W-1:0] cfg_order,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  output logic                       ram_we,
  output logic [smi_pkg::ADDR_W-1:0] ram_waddr,
  output logic [smi_pkg::ADDR_W-1:0] ram_raddr,
  output smi_pkg::dp_cmd_t           cmd,
  input  smi_pkg::dp_status_t        status
);
  import smi_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_MSTART, S_PERM, S_FACT, S_WAIT, S_MUL, S_ADD,
    S_MDONE, S_DIV, S_ROUND, S_EMIT, S_SING
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [ORDER_W-1:0]     n_r, n_nxt;
  logic [ORDER_W-1:0]     m_r, m_nxt;
  logic                   det_mode_r, det_mode_nxt;
  logic [ORDER_W-1:0]     skip_row_r, skip_row_nxt;
  logic [ORDER_W-1:0]     skip_col_r, skip_col_nxt;
  logic [PERM_IDX_W-1:0]  perm_r, perm_nxt;
  logic [ORDER_W-1:0]     p_r, p_nxt;
  logic [1:0]             limb_r, limb_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [1:0]             i_r, i_nxt;
  logic [1:0]             j_r, j_nxt;

  logic [ORDER_W-1:0]     order_n;
  logic [5:0]             total_w;
  logic [CNT_W-1:0]       total;
  logic [CNT_W-1:0]       cnt_inc;
  logic [8:0]             pe;
  logic [1:0]             perm_col;
  logic                   tail_ok;
  logic [ORDER_W-1:0]     row_sel;
  logic [ORDER_W-1:0]     col_sel;
  logic [5:0]             row_base;
  logic [ORDER_W-1:0]     n_less;
  logic                   i_end;
  logic                   j_end;

  always_comb begin
    order_n  = order_clamp(cfg_order);
    total_w  = order_n * order_n;
    total    = total_w[CNT_W-1:0];
    cnt_inc  = (cnt_r < CNT_W'(STORE_DEPTH)) ? cnt_r + 1'b1 : cnt_r;
    pe       = perm_entry(perm_r);
    perm_col = pe[{p_r[1:0], 1'b0} +: 2];
    tail_ok  = 1'b1;
    for (int q = 0; q < MAX_ORDER; q++) begin
      if ((ORDER_W'(q) >= m_r) && (pe[2*q +: 2] != 2'(q))) tail_ok = 1'b0;
    end
    row_sel   = (p_r < skip_row_r) ? p_r : p_r + 1'b1;
    col_sel   = ({1'b0, perm_col} < skip_col_r) ? {1'b0, perm_col} : {1'b0, perm_col} + 1'b1;
    row_base  = row_sel * n_r;
    ram_raddr = row_base[ADDR_W-1:0] + ADDR_W'(col_sel);
    ram_waddr = cnt_r[ADDR_W-1:0];
    n_less    = n_r - 1'b1;
    i_end     = ({1'b0, i_r} == n_less);
    j_end     = ({1'b0, j_r} == n_less);
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    n_nxt        = n_r;
    m_nxt        = m_r;
    det_mode_nxt = det_mode_r;
    skip_row_nxt = skip_row_r;
    skip_col_nxt = skip_col_r;
    perm_nxt     = perm_r;
    p_nxt        = p_r;
    limb_nxt     = limb_r;
    step_nxt     = step_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    in_tready    = 1'b0;
    ram_we       = 1'b0;
    cmd          = '{op: OP_NONE, limb: limb_r, odd: 1'b0, first: 1'b0, last: 1'b0};

    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ram_we = 1'b1;
          if (cnt_inc >= total) begin
            cnt_nxt      = '0;
            n_nxt        = order_n;
            m_nxt        = order_n;
            det_mode_nxt = 1'b1;
            skip_row_nxt = ORDER_W'(MAX_ORDER);
            skip_col_nxt = ORDER_W'(MAX_ORDER);
            state_nxt    = S_MSTART;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      S_MSTART: begin
        cmd.op    = OP_ACC_CLR;
        perm_nxt  = '0;
        state_nxt = S_PERM;
      end
      S_PERM: begin
        if (tail_ok) begin
          cmd.op    = OP_PROD_INIT;
          cmd.odd   = pe[8];
          p_nxt     = '0;
          state_nxt = S_FACT;
        end else if (perm_r == PERM_IDX_W'(LAST_PERM)) begin
          state_nxt = S_MDONE;
        end else begin
          perm_nxt = perm_r + 1'b1;
        end
      end
      S_FACT: begin
        state_nxt = (p_r == m_r) ? S_ADD : S_WAIT;
      end
      S_WAIT: begin
        cmd.op    = OP_ELEM;
        limb_nxt  = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op   = OP_MUL;
        cmd.last = (limb_r == 2'd3);
        if (limb_r == 2'd3) begin
          p_nxt     = p_r + 1'b1;
          state_nxt = S_FACT;
        end else begin
          limb_nxt = limb_r + 1'b1;
        end
      end
      S_ADD: begin
        cmd.op = OP_ACC_ADD;
        if (perm_r == PERM_IDX_W'(LAST_PERM)) begin
          state_nxt = S_MDONE;
        end else begin
          perm_nxt  = perm_r + 1'b1;
          state_nxt = S_PERM;
        end
      end
      S_MDONE: begin
        if (det_mode_r) begin
          if (status.acc_zero) begin
            state_nxt = S_SING;
          end else begin
            cmd.op       = OP_DET_TAKE;
            det_mode_nxt = 1'b0;
            i_nxt        = '0;
            j_nxt        = '0;
            skip_row_nxt = '0;
            skip_col_nxt = '0;
            m_nxt        = n_r - 1'b1;
            state_nxt    = S_MSTART;
          end
        end else begin
          cmd.op    = OP_DIV_INIT;
          cmd.odd   = i_r[0] ^ j_r[0];
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op    = OP_DIV_STEP;
        cmd.first = (step_r == '0);
        if (step_r == STEP_W'(DIV_LAST)) begin
          state_nxt = S_ROUND;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_ROUND: begin
        cmd.op    = OP_ROUND;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op   = OP_OUT_RES;
          cmd.last = i_end && j_end;
          if (i_end && j_end) begin
            state_nxt = S_LOAD;
          end else if (j_end) begin
            j_nxt        = '0;
            i_nxt        = i_r + 1'b1;
            skip_row_nxt = '0;
            skip_col_nxt = ORDER_W'(i_r) + 1'b1;
            state_nxt    = S_MSTART;
          end else begin
            j_nxt        = j_r + 1'b1;
            skip_row_nxt = ORDER_W'(j_r) + 1'b1;
            skip_col_nxt = ORDER_W'(i_r);
            state_nxt    = S_MSTART;
          end
        end
      end
      S_SING: begin
        if (status.out_free) begin
          cmd.op    = OP_OUT_SING;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      cnt_r      <= '0;
      n_r        <= ORDER_RESET;
      m_r        <= ORDER_RESET;
      det_mode_r <= 1'b0;
      skip_row_r <= '0;
      skip_col_r <= '0;
      perm_r     <= '0;
      p_r        <= '0;
      limb_r     <= '0;
      step_r     <= '0;
      i_r        <= '0;
      j_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      n_r        <= n_nxt;
      m_r        <= m_nxt;
      det_mode_r <= det_mode_nxt;
      skip_row_r <= skip_row_nxt;
      skip_col_r <= skip_col_nxt;
      perm_r     <= perm_nxt;
      p_r        <= p_nxt;
      limb_r     <= limb_nxt;
      step_r     <= step_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
    end
  end

endmodule

// ----- design/smi_dp.sv -----
module smi_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  smi_pkg::dp_cmd_t           cmd,
  output smi_pkg::dp_status_t        status,
  input  logic [smi_pkg::DATA_W-1:0] ram_rdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [smi_pkg::DATA_W-1:0] out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);
  import smi_pkg::*;

  logic [DATA_W-1:0] e_mag_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] tmp_r;
  logic              psign_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  dmag_r;
  logic              dneg_r;
  logic [ACC_W-1:0]  rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic              sat_r;
  logic              qneg_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_user_r;
  logic              out_last_r;

  logic [DATA_W-1:0] limb_val;
  logic [63:0]       part;
  logic [PROD_W-1:0] part_shift;
  logic [PROD_W-1:0] tsum;
  logic [ACC_W-1:0]  acc_mag;
  logic [ACC_W-1:0]  rr;
  logic              ge;
  logic [DATA_W-1:0] res_val;
  logic              out_free;

  always_comb begin
    limb_val   = prod_r[{cmd.limb, 5'd0} +: DATA_W];
    part       = limb_val * e_mag_r;
    part_shift = {64'd0, part} << {cmd.limb, 5'd0};
    tsum       = tmp_r + part_shift;
    acc_mag    = acc_r[ACC_W-1] ? (~acc_r + 1'b1) : acc_r;
    rr         = cmd.first ? rem_r : {rem_r[ACC_W-2:0], 1'b0};
    ge         = (rr >= dmag_r);
    if (!qneg_r) begin
      res_val = (sat_r || quo_r >= QUO_W'(34'h080000000)) ? 32'h7FFFFFFF : quo_r[DATA_W-1:0];
    end else begin
      res_val = (sat_r || quo_r > QUO_W'(34'h080000000)) ? 32'h80000000
                                                         : (~quo_r[DATA_W-1:0] + 1'b1);
    end
    out_free        = !out_valid_r || out_tready;
    status.out_free = out_free;
    status.acc_zero = (acc_r == '0);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACC_CLR: begin
        acc_r <= '0;
      end
      OP_PROD_INIT: begin
        prod_r  <= PROD_W'(1);
        psign_r <= cmd.odd;
      end
      OP_ELEM: begin
        e_mag_r <= ram_rdata[DATA_W-1] ? (~ram_rdata + 1'b1) : ram_rdata;
        psign_r <= psign_r ^ ram_rdata[DATA_W-1];
        tmp_r   <= '0;
      end
      OP_MUL: begin
        if (cmd.last) begin
          prod_r <= tsum;
        end else begin
          tmp_r <= tsum;
        end
      end
      OP_ACC_ADD: begin
        acc_r <= psign_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
      end
      OP_DET_TAKE: begin
        dneg_r <= acc_r[ACC_W-1];
        dmag_r <= acc_mag;
      end
      OP_DIV_INIT: begin
        qneg_r <= acc_r[ACC_W-1] ^ cmd.odd ^ dneg_r;
        sat_r  <= (acc_mag >= {dmag_r[ACC_W-2:0], 1'b0});
        rem_r  <= acc_mag;
        quo_r  <= '0;
      end
      OP_DIV_STEP: begin
        rem_r <= ge ? rr - dmag_r : rr;
        quo_r <= {quo_r[QUO_W-2:0], ge};
      end
      OP_ROUND: begin
        if ({rem_r[ACC_W-2:0], 1'b0} >= dmag_r) begin
          quo_r <= quo_r + 1'b1;
        end
      end
      OP_OUT_RES: begin
        out_data_r <= res_val;
        out_user_r <= 1'b0;
        out_last_r <= cmd.last;
      end
      OP_OUT_SING: begin
        out_data_r <= '0;
        out_user_r <= 1'b1;
        out_last_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT_RES || cmd.op == OP_OUT_SING) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- design/small_matrix_inverse.sv -----
// Operation: elements load one per cycle; after the last one, the shared 32x32 limb
// multiplier walks every permutation product, then a 33-step divider runs for each
// inverse element.
// Throughput: one matrix at a time; no input transaction is taken while it is worked.
// Reset (rst_n, synchronous): load count cleared, order register back to 4, output empty.
module small_matrix_inverse (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [smi_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // [31:0] element_value
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [31:0] result_value
  output logic                           out_tuser,  // [0] singular
  output logic                           out_tlast
);
  import smi_pkg::*;

  logic [ORDER_W-1:0] order_r;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;
  dp_cmd_t            cmd;
  dp_status_t         status;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_ORDER_ADDR) ? {29'd0, order_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == CFG_ORDER_ADDR) begin
      order_r <= cfg_pwdata[ORDER_W-1:0];
    end
  end

  smi_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_tdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  smi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_order(order_r),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_raddr(ram_raddr),
    .cmd      (cmd),
    .status   (status)
  );

  smi_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .ram_rdata (ram_rdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
